[hw/rtl/sbq_pkg.sv]
package sbq_pkg;

	// Build-time constants of the arithmetic
	localparam int MAX_CHANNELS_DEF = 8;
	localparam int PHASE_BITS       = 24;
	localparam int SINE_TABLE_DEPTH = 1024;   // power of two
	localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
	localparam int COEF_FRAC_BITS   = 22;

	// Field widths
	localparam int SAMPLE_W   = 16;
	localparam int CH_W       = 3;
	localparam int HIST_Y_W   = 32;            // Q24.8 output history
	localparam int Y_FRAC_BITS = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int CHANNELS_W = 4;
	localparam int LFO_STEP_W = 24;
	localparam int CENTRE_W   = 23;
	localparam int DEPTH_W    = 23;
	localparam int GAIN_W     = 22;
	localparam int B2_W       = 24;
	localparam int RES_W      = 22;

	// Datapath widths
	localparam int SINE_W = COEF_FRAC_BITS + 2;
	localparam int B1_W   = 25;
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 64;
	localparam int Q30_W  = 31;

	localparam logic [Q30_W-1:0] Q30_ONE = Q30_W'(1) << 30;
	localparam logic [Q30_W-1:0] POLY_A  = Q30_W'(1686629713);
	localparam logic [Q30_W-1:0] POLY_B  = Q30_W'(688904863);
	localparam logic [Q30_W-1:0] POLY_C  = Q30_W'(76016983);

	typedef struct packed {
		logic [CHANNELS_W-1:0]  channels_in_use;
		logic [LFO_STEP_W-1:0]  lfo_step;
		logic [CENTRE_W-1:0]    centre_phase;
		logic [DEPTH_W-1:0]     depth_phase;
		logic [GAIN_W-1:0]      gain_a0;
		logic signed [B2_W-1:0] feedback_b2;
		logic [RES_W-1:0]       resonance_scale;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		channels_in_use: 4'd2,
		lfo_step:        24'd76,
		centre_phase:    23'd760871,
		depth_phase:     23'd684784,
		gain_a0:         22'd14887,
		feedback_b2:     24'sd4164529,
		resonance_scale: 22'd4179419
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNELS,
		REG_LFO_STEP,
		REG_CENTRE,
		REG_DEPTH,
		REG_GAIN,
		REG_B2,
		REG_RES
	} cfg_reg_t;

	// Microcode
	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_TT,
		MUL_CT2,
		MUL_PT2,
		MUL_PT,
		MUL_DEPTH,
		MUL_RES,
		MUL_GAIN,
		MUL_B1Y1,
		MUL_B2Y2
	} mul_sel_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_SIN_LFO,
		OP_SIN_FC,
		OP_T2,
		OP_PB,
		OP_PA,
		OP_SFIN,
		OP_B1,
		OP_ACC_LD,
		OP_ACC_SUB,
		OP_SAT,
		OP_OUT
	} op_t;

	typedef enum logic {
		JMP_NONE,
		JMP_NOT_FRAME
	} jmp_t;

	typedef struct packed {
		mul_sel_t mul;
		op_t      op;
		jmp_t     jmp;
		step_t    target;
		logic     last;
	} ctrl_t;

	localparam ctrl_t CTRL_NOP = '{
		mul: MUL_NONE, op: OP_NOP, jmp: JMP_NONE, target: '0, last: 1'b0
	};

	typedef struct packed {
		logic                       wr;
		logic signed [SAMPLE_W-1:0] sample;
		logic [CH_W-1:0]            ch;
	} result_t;

endpackage

[hw/rtl/sbq_sequencer.sv]
module sbq_sequencer
	import sbq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  is_frame,
	input  logic  hold,
	output ctrl_t ctrl,
	output logic  busy
);

	localparam int    UCODE_LEN   = 27;
	localparam step_t STEP_SAMPLE = step_t'(21);

	function automatic ctrl_t cw(mul_sel_t m, op_t o);
		ctrl_t w;
		w = '{mul: m, op: o, jmp: JMP_NONE, target: '0, last: 1'b0};
		return w;
	endfunction

	// Sine polynomial takes 8 steps: t^2, C*t^2, B-, *t^2, A-, *t, finish
	function automatic ctrl_t ucode(step_t s);
		ctrl_t w;
		case (s)
			5'd0: w = '{mul: MUL_NONE, op: OP_SIN_LFO, jmp: JMP_NOT_FRAME,
				target: STEP_SAMPLE, last: 1'b0};
			5'd1:  w = cw(MUL_TT,    OP_NOP);
			5'd2:  w = cw(MUL_NONE,  OP_T2);
			5'd3:  w = cw(MUL_CT2,   OP_NOP);
			5'd4:  w = cw(MUL_NONE,  OP_PB);
			5'd5:  w = cw(MUL_PT2,   OP_NOP);
			5'd6:  w = cw(MUL_NONE,  OP_PA);
			5'd7:  w = cw(MUL_PT,    OP_NOP);
			5'd8:  w = cw(MUL_NONE,  OP_SFIN);
			5'd9:  w = cw(MUL_DEPTH, OP_NOP);
			5'd10: w = cw(MUL_NONE,  OP_SIN_FC);
			5'd11: w = cw(MUL_TT,    OP_NOP);
			5'd12: w = cw(MUL_NONE,  OP_T2);
			5'd13: w = cw(MUL_CT2,   OP_NOP);
			5'd14: w = cw(MUL_NONE,  OP_PB);
			5'd15: w = cw(MUL_PT2,   OP_NOP);
			5'd16: w = cw(MUL_NONE,  OP_PA);
			5'd17: w = cw(MUL_PT,    OP_NOP);
			5'd18: w = cw(MUL_NONE,  OP_SFIN);
			5'd19: w = cw(MUL_RES,   OP_NOP);
			5'd20: w = cw(MUL_NONE,  OP_B1);
			5'd21: w = cw(MUL_GAIN,  OP_NOP);
			5'd22: w = cw(MUL_B1Y1,  OP_ACC_LD);
			5'd23: w = cw(MUL_B2Y2,  OP_ACC_SUB);
			5'd24: w = cw(MUL_NONE,  OP_ACC_SUB);
			5'd25: w = cw(MUL_NONE,  OP_SAT);
			5'd26: w = '{mul: MUL_NONE, op: OP_OUT, jmp: JMP_NONE,
				target: '0, last: 1'b1};
			default: w = '{mul: MUL_NONE, op: OP_NOP, jmp: JMP_NONE,
				target: '0, last: 1'b1};
		endcase
		return w;
	endfunction

	step_t step_q;
	logic  busy_q;
	ctrl_t rom_cw;
	logic  stall;

	assign rom_cw = ucode(step_q);
	assign stall  = rom_cw.last && hold;
	assign busy   = busy_q;

	always_comb begin
		ctrl = CTRL_NOP;
		if (busy_q && !stall) begin
			ctrl = rom_cw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q && !stall) begin
			if (rom_cw.last) begin
				busy_q <= 1'b0;
			end else if (rom_cw.jmp == JMP_NOT_FRAME && !is_frame) begin
				step_q <= rom_cw.target;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("request started while sequencer busy");

	a_hold_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && stall) |=> (busy_q && $stable(step_q)))
		else $error("final step left while result slot full");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q < step_t'(UCODE_LEN)))
		else $error("step counter outside program");

endmodule

[hw/rtl/sbq_datapath.sv]
module sbq_datapath
	import sbq_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)(
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       load,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [CH_W-1:0]            ch,
	input  ctrl_t                      ctrl,
	output logic                       is_frame,
	output result_t                    res
);

	localparam int SLOT_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W  = ($clog2(MAX_CHANNELS + 1) > CHANNELS_W) ?
		$clog2(MAX_CHANNELS + 1) : CHANNELS_W;
	localparam int YD_W   = HIST_Y_W - Y_FRAC_BITS;

	localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);
	localparam logic signed [PROD_W-1:0] B1_MAX = PROD_W'((2 ** (B1_W - 1)) - 1);
	localparam logic signed [PROD_W-1:0] B1_MIN = -PROD_W'(2 ** (B1_W - 1));
	localparam logic signed [ACC_W-1:0]  Y_MAX  = ACC_W'({1'b0, {(HIST_Y_W-1){1'b1}}});
	localparam logic signed [ACC_W-1:0]  Y_MIN  = ~Y_MAX;
	localparam logic signed [YD_W-1:0]   S_MAX  = YD_W'((2 ** (SAMPLE_W - 1)) - 1);
	localparam logic signed [YD_W-1:0]   S_MIN  = -YD_W'(2 ** (SAMPLE_W - 1));

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x1;
		logic signed [SAMPLE_W-1:0] x2;
		logic signed [HIST_Y_W-1:0] y1;
		logic signed [HIST_Y_W-1:0] y2;
	} hist_t;

	typedef struct packed {
		logic [1:0]       quad;
		logic [Q30_W-1:0] t;
	} sin_arg_t;

	function automatic logic [SLOT_W-1:0] slot_of(logic [CH_W-1:0] c);
		logic [CNT_W:0] r;
		r = (CNT_W+1)'(c);
		for (int i = 0; i < (1 << CH_W); i++) begin
			if (r >= (CNT_W+1)'(MAX_CHANNELS)) begin
				r = r - (CNT_W+1)'(MAX_CHANNELS);
			end
		end
		return SLOT_W'(r);
	endfunction

	// Quantize phase to the table grid, fold into a quadrant, Q30 position
	function automatic sin_arg_t sine_arg(logic [PHASE_BITS-1:0] ph);
		logic [SINE_IDX_BITS-1:0] idx;
		logic [Q30_W-1:0]         tr;
		sin_arg_t                 a;
		idx    = ph[PHASE_BITS-1 -: SINE_IDX_BITS];
		tr     = {1'b0, idx[SINE_IDX_BITS-3:0], (32 - SINE_IDX_BITS)'(0)};
		a.quad = idx[SINE_IDX_BITS-1 -: 2];
		a.t    = a.quad[0] ? (Q30_ONE - tr) : tr;
		return a;
	endfunction

	// State
	hist_t                    hist_q [MAX_CHANNELS];
	logic [PHASE_BITS-1:0]    lfo_phase_q;
	logic signed [B1_W-1:0]   b1_q;

	// Working registers
	logic signed [SAMPLE_W-1:0] x0_q;
	logic [CH_W-1:0]            ch_q;
	logic [Q30_W-1:0]           t_q;
	logic [Q30_W-1:0]           t2_q;
	logic [Q30_W-1:0]           p_q;
	logic [1:0]                 quad_q;
	logic signed [SINE_W-1:0]   sl_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [HIST_Y_W-1:0] y_q;

	logic [SLOT_W-1:0]          slot;
	hist_t                      hrow;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [MUL_W-1:0]    mul_a;
	logic signed [MUL_W-1:0]    mul_b;
	logic [Q30_W-1:0]           q30;
	logic [Q30_W-1:0]           q30_clamped;
	logic [COEF_FRAC_BITS:0]    mag;
	logic signed [SINE_W-1:0]   sine_val;
	logic [PHASE_BITS-1:0]      fc_phase;
	sin_arg_t                   arg_lfo;
	sin_arg_t                   arg_fc;
	logic signed [PROD_W-1:0]   fb_shift;
	logic signed [PROD_W-1:0]   fb_neg;
	logic signed [B1_W-1:0]     b1_next;
	logic signed [ACC_W-1:0]    acc_sh;
	logic signed [HIST_Y_W-1:0] y_next;
	logic signed [YD_W-1:0]     y_div;
	logic signed [SAMPLE_W-1:0] s_sat;
	logic [CNT_W-1:0]           cnt;
	logic                       frame_end;

	assign slot     = slot_of(ch_q);
	assign hrow     = hist_q[slot];
	assign is_frame = (ch_q == '0);
	assign diff     = (SAMPLE_W+1)'(x0_q) - (SAMPLE_W+1)'(hrow.x2);
	assign q30      = prod_q[30 +: Q30_W];

	// centre + depth*sin, wrapped, plus a quarter circle for the cosine
	assign fc_phase = PHASE_BITS'(cfg.centre_phase)
		+ prod_q[COEF_FRAC_BITS +: PHASE_BITS] + QUARTER;
	assign arg_lfo  = sine_arg(lfo_phase_q);
	assign arg_fc   = sine_arg(fc_phase);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.mul)
			MUL_TT: begin
				mul_a = MUL_W'(t_q);
				mul_b = MUL_W'(t_q);
			end
			MUL_CT2: begin
				mul_a = MUL_W'(POLY_C);
				mul_b = MUL_W'(t2_q);
			end
			MUL_PT2: begin
				mul_a = MUL_W'(p_q);
				mul_b = MUL_W'(t2_q);
			end
			MUL_PT: begin
				mul_a = MUL_W'(p_q);
				mul_b = MUL_W'(t_q);
			end
			MUL_DEPTH: begin
				mul_a = MUL_W'(cfg.depth_phase);
				mul_b = MUL_W'(sl_q);
			end
			MUL_RES: begin
				mul_a = MUL_W'(cfg.resonance_scale);
				mul_b = MUL_W'(sl_q);
			end
			MUL_GAIN: begin
				mul_a = MUL_W'(cfg.gain_a0);
				mul_b = MUL_W'(diff);
			end
			MUL_B1Y1: begin
				mul_a = MUL_W'(b1_q);
				mul_b = MUL_W'(hrow.y1);
			end
			MUL_B2Y2: begin
				mul_a = MUL_W'(cfg.feedback_b2);
				mul_b = MUL_W'(hrow.y2);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		q30_clamped = (q30 > Q30_ONE) ? Q30_ONE : q30;
		mag         = q30_clamped[30 -: COEF_FRAC_BITS + 1];
		sine_val    = quad_q[1] ? -SINE_W'(mag) : SINE_W'(mag);

		// b1 = -(scale * 2cos) >> frac, the doubling folded into the shift
		fb_shift = prod_q >>> (COEF_FRAC_BITS - 1);
		fb_neg   = -fb_shift;
		if (fb_neg > B1_MAX) begin
			b1_next = B1_W'(B1_MAX);
		end else if (fb_neg < B1_MIN) begin
			b1_next = B1_W'(B1_MIN);
		end else begin
			b1_next = B1_W'(fb_neg);
		end

		acc_sh = acc_q >>> COEF_FRAC_BITS;
		if (acc_sh > Y_MAX) begin
			y_next = HIST_Y_W'(Y_MAX);
		end else if (acc_sh < Y_MIN) begin
			y_next = HIST_Y_W'(Y_MIN);
		end else begin
			y_next = HIST_Y_W'(acc_sh);
		end

		y_div = y_q[HIST_Y_W-1:Y_FRAC_BITS];
		if (y_div > S_MAX) begin
			s_sat = SAMPLE_W'(S_MAX);
		end else if (y_div < S_MIN) begin
			s_sat = SAMPLE_W'(S_MIN);
		end else begin
			s_sat = SAMPLE_W'(y_div);
		end

		cnt = CNT_W'(cfg.channels_in_use);
		if (cnt == '0) begin
			cnt = CNT_W'(1);
		end
		if (cnt > CNT_W'(MAX_CHANNELS)) begin
			cnt = CNT_W'(MAX_CHANNELS);
		end
		frame_end = (CNT_W'(ch_q) == cnt - 1'b1);
	end

	assign res.wr     = (ctrl.op == OP_OUT);
	assign res.sample = s_sat;
	assign res.ch     = ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfo_phase_q <= '0;
			b1_q        <= '0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (ctrl.op == OP_B1) begin
				b1_q <= b1_next;
			end
			if (ctrl.op == OP_OUT) begin
				hist_q[slot] <= '{x1: x0_q, x2: hrow.x1, y1: y_q, y2: hrow.y1};
				if (frame_end) begin
					lfo_phase_q <= lfo_phase_q + PHASE_BITS'(cfg.lfo_step);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (load) begin
			x0_q <= sample;
			ch_q <= ch;
		end
		case (ctrl.op)
			OP_SIN_LFO: begin
				t_q    <= arg_lfo.t;
				quad_q <= arg_lfo.quad;
			end
			OP_SIN_FC: begin
				t_q    <= arg_fc.t;
				quad_q <= arg_fc.quad;
			end
			OP_T2:      t2_q  <= q30;
			OP_PB:      p_q   <= POLY_B - q30;
			OP_PA:      p_q   <= POLY_A - q30;
			OP_SFIN:    sl_q  <= sine_val;
			OP_ACC_LD:  acc_q <= ACC_W'(prod_q) <<< Y_FRAC_BITS;
			OP_ACC_SUB: acc_q <= acc_q - ACC_W'(prod_q);
			OP_SAT:     y_q   <= y_next;
			default: ;
		endcase
	end

endmodule

[hw/rtl/swept_bandpass_biquad.sv]
// Swept band-pass biquad with a sine LFO on the center frequency.
//
// Item channel (item_valid/item_ready): one request carries a signed 16-bit
// sample and its channel number; channel 0 opens a frame. Result channel
// (result_valid/result_ready): one filtered, saturated sample per request,
// with the channel echoed, in request order.
// Config channel (cfg_valid/cfg_ready): always ready; cfg_index picks the
// register, cfg_data carries it right-aligned. Write only while idle.
//
// A channel 0 request runs the whole microcode program: two sine evaluations
// plus the b1 update, all on one shared 33x33 multiplier, before the filter
// steps; any other channel jumps straight to the filter steps.
// The microcode sequencer runs one request at a time; a new request is taken
// only once it is idle again.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls and a second result is ready, the
// sequencer holds on its last step until the output register frees.
// Reset (arst_n low) clears all channel history, the LFO phase and b1, and
// loads the configuration defaults.
module swept_bandpass_biquad
	import sbq_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic [CH_W-1:0]            channel,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic [CH_W-1:0]            channel_out,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	cfg_t    cfg_q;
	ctrl_t   ctrl;
	result_t dp_res;
	logic    seq_busy;
	logic    is_frame;
	logic    accept;
	logic    hold;

	logic                       result_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic [CH_W-1:0]            channel_out_q;

	assign item_ready   = !seq_busy;
	assign accept       = item_valid && item_ready;
	assign cfg_ready    = 1'b1;

	// Result register full and not drained this cycle: last step must wait
	assign hold         = result_valid_q && !result_ready;

	assign result_valid = result_valid_q;
	assign sample_out   = sample_out_q;
	assign channel_out  = channel_out_q;

	// Config registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_CHANNELS: cfg_q.channels_in_use <= cfg_data[CHANNELS_W-1:0];
				REG_LFO_STEP: cfg_q.lfo_step        <= cfg_data[LFO_STEP_W-1:0];
				REG_CENTRE:   cfg_q.centre_phase    <= cfg_data[CENTRE_W-1:0];
				REG_DEPTH:    cfg_q.depth_phase     <= cfg_data[DEPTH_W-1:0];
				REG_GAIN:     cfg_q.gain_a0         <= cfg_data[GAIN_W-1:0];
				REG_B2:       cfg_q.feedback_b2     <= cfg_data[B2_W-1:0];
				REG_RES:      cfg_q.resonance_scale <= cfg_data[RES_W-1:0];
				default: ;
			endcase
		end
	end

	sbq_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.is_frame (is_frame),
		.hold     (hold),
		.ctrl     (ctrl),
		.busy     (seq_busy)
	);

	sbq_datapath #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.load     (accept),
		.sample   (sample_in),
		.ch       (channel),
		.ctrl     (ctrl),
		.is_frame (is_frame),
		.res      (dp_res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (dp_res.wr) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_res.wr) begin
			sample_out_q  <= dp_res.sample;
			channel_out_q <= dp_res.ch;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_res.wr |-> !(result_valid_q && !result_ready))
		else $error("result written over a pending result");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("second request taken while one in flight");

endmodule
